// ----- rtl/ats_pkg.sv -----
// Package for the alignment tile scorer: shared types, codes and helpers.
// No dependencies.
package ats_pkg;
  localparam int ScoreW = 32;
  localparam int SymW   = 2;
  localparam int DimW   = 4;
  localparam int CfgDataW = 40;
  localparam int CfgIdxW  = 3;

  typedef enum logic [1:0] {
    REQ_TOP  = 2'd0,
    REQ_LEFT = 2'd1,
    REQ_COL  = 2'd2,
    REQ_ROW  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_ROW_A   = 3'd2,
    CFG_ROW_C   = 3'd3,
    CFG_ROW_G   = 3'd4,
    CFG_ROW_T   = 3'd5,
    CFG_ROW_GAP = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_CELL,
    ST_ROWEND,
    ST_EMIT_B,
    ST_EMIT_R
  } state_t;

  // Saturate a 34-bit signed sum to 32 bits
  function automatic logic signed [ScoreW-1:0] sat32(input logic signed [ScoreW+1:0] v);
    logic signed [ScoreW+1:0] hi;
    logic signed [ScoreW+1:0] lo;
    begin
      hi = (ScoreW+2)'(signed'(33'sh0_7FFF_FFFF));
      lo = -hi - (ScoreW+2)'(1);
      if (v > hi) sat32 = hi[ScoreW-1:0];
      else if (v < lo) sat32 = lo[ScoreW-1:0];
      else sat32 = v[ScoreW-1:0];
    end
  endfunction
endpackage

// ----- rtl/ats_if.sv -----
// Valid/ready channel interfaces for the tile scorer.
// Depends on ats_pkg.
interface ats_in_if import ats_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [DimW-1:0]   position;
  logic signed [ScoreW-1:0] value;
  logic              last;
  modport source (output valid, req_type, position, value, last, input ready);
  modport sink   (input valid, req_type, position, value, last, output ready);
endinterface

interface ats_out_if import ats_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              edge_res;
  logic [DimW-1:0]   position_res;
  logic signed [ScoreW-1:0] score;
  logic              end_of_run;
  modport source (output valid, edge_res, position_res, score, end_of_run, input ready);
  modport sink   (input valid, edge_res, position_res, score, end_of_run, output ready);
endinterface

// ----- rtl/ats_cell.sv -----
// Cell update: three saturated candidates and their maximum.
// Depends on ats_pkg.
module ats_cell import ats_pkg::*; (
  input  logic signed [ScoreW-1:0] diag,
  input  logic signed [ScoreW-1:0] left,
  input  logic signed [ScoreW-1:0] top,
  input  logic signed [7:0]        s_diag,
  input  logic signed [7:0]        s_left,
  input  logic signed [7:0]        s_top,
  output logic signed [ScoreW-1:0] best
);
  logic signed [ScoreW-1:0] d, l, t, m;
  // Form candidates and pick the largest
  always_comb begin
    d = sat32((ScoreW+2)'(diag) + (ScoreW+2)'(s_diag));
    l = sat32((ScoreW+2)'(left) + (ScoreW+2)'(s_left));
    t = sat32((ScoreW+2)'(top)  + (ScoreW+2)'(s_top));
    m = l;
    if (t > m) m = t;
    if (d > m) m = d;
    best = m;
  end
endmodule

// ----- rtl/alignment_tile_score.sv -----
// Tile scorer for a tiled sequence-alignment matrix. Load transfers fill the top halo,
// left halo and symbol stores one per cycle. A transfer marked last starts scoring: first
// the right edge of the top halo is recorded; then each row is fetched from memory,
// updated column by column, with the row buffer read and written back in a
// single-port-read synchronous memory, and its right edge recorded. After the last row,
// the bottom row (W+1 values) and right column (H+1 values) leave one per cycle while the
// receiver is ready. No load is taken while scoring or emitting. Dimensions above
// MAX_TILE are clamped; zero emits the halo values directly.
// Depends on ats_pkg, ats_if and ats_cell.
module alignment_tile_score import ats_pkg::*; #(
  parameter int MAX_TILE = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  ats_in_if.sink               in_ch,
  ats_out_if.source            out_ch
);
  localparam int AW = $clog2(MAX_TILE + 1);

  // Configuration registers
  logic [DimW-1:0]     tw_r, th_r;
  logic [CfgDataW-1:0] srow_r [5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= DimW'(15);
      th_r <= DimW'(15);
      for (int i = 0; i < 5; i++) srow_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:   tw_r <= cfg_data[DimW-1:0];
        CFG_HEIGHT:  th_r <= cfg_data[DimW-1:0];
        CFG_ROW_A:   srow_r[0] <= cfg_data;
        CFG_ROW_C:   srow_r[1] <= cfg_data;
        CFG_ROW_G:   srow_r[2] <= cfg_data;
        CFG_ROW_T:   srow_r[3] <= cfg_data;
        CFG_ROW_GAP: srow_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [7:0] tab(input logic [2:0] r, input logic [2:0] c);
    logic [CfgDataW-1:0] row;
    begin
      row = srow_r[r];
      tab = row[8*c +: 8];
    end
  endfunction

  logic [AW-1:0] w_c, h_c;
  always_comb begin
    w_c = (32'(tw_r) > MAX_TILE) ? AW'(MAX_TILE) : AW'(tw_r);
    h_c = (32'(th_r) > MAX_TILE) ? AW'(MAX_TILE) : AW'(th_r);
  end

  // Memories and symbol registers
  logic signed [ScoreW-1:0] rowmem [MAX_TILE+1];
  logic signed [ScoreW-1:0] leftmem [MAX_TILE+1];
  logic signed [ScoreW-1:0] rightmem [MAX_TILE+1];
  logic [SymW-1:0] csym_r [MAX_TILE];
  logic [SymW-1:0] rsym_r [MAX_TILE];

  state_t st_r, st_nxt;
  logic [AW-1:0] r_r, r_nxt, c_r, c_nxt;
  logic signed [ScoreW-1:0] diag_r, diag_nxt, left_r, left_nxt;
  logic signed [ScoreW-1:0] rd_q, lh_q, re_q;
  logic [AW-1:0] rd_addr, lh_addr, re_addr;
  logic row_we, re_we;
  logic [AW-1:0] row_wa, re_wa;
  logic signed [ScoreW-1:0] row_wd, re_wd;
  logic signed [ScoreW-1:0] cell_v;
  logic oval_r, oval_nxt, oedge_r, oedge_nxt, oend_r, oend_nxt;
  logic [DimW-1:0] opos_r, opos_nxt;
  logic signed [ScoreW-1:0] oscore_r, oscore_nxt;
  logic in_fire, out_free;
  logic [1:0] y_sym, x_sym;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !oval_r || out_ch.ready;
  assign in_ch.ready = (st_r == ST_LOAD) && !oval_r;

  // Loads of symbols
  always_ff @(posedge clk) begin
    if (in_fire && 32'(in_ch.position) < MAX_TILE) begin
      if (in_ch.req_type == REQ_COL) csym_r[AW'(in_ch.position)] <= in_ch.value[SymW-1:0];
      if (in_ch.req_type == REQ_ROW) rsym_r[AW'(in_ch.position)] <= in_ch.value[SymW-1:0];
    end
  end

  // Memory ports; forward a same-cycle row write to the row read port
  always_ff @(posedge clk) begin
    if (row_we) rowmem[row_wa] <= row_wd;
    if (row_we && row_wa == rd_addr) rd_q <= row_wd;
    else rd_q <= rowmem[rd_addr];
    if (in_fire && in_ch.req_type == REQ_LEFT && 32'(in_ch.position) <= MAX_TILE)
      leftmem[AW'(in_ch.position)] <= in_ch.value;
    lh_q <= leftmem[lh_addr];
    if (re_we) rightmem[re_wa] <= re_wd;
    re_q <= rightmem[re_addr];
  end

  assign y_sym = rsym_r[(r_r == '0) ? AW'(0) : AW'(r_r - AW'(1))];
  assign x_sym = csym_r[(c_r == '0) ? AW'(0) : AW'(c_r - AW'(1))];

  ats_cell u_cell (
    .diag(diag_r), .left(left_r), .top(rd_q),
    .s_diag(tab({1'b0, y_sym}, {1'b0, x_sym})),
    .s_left(tab({1'b0, x_sym}, 3'd4)),
    .s_top(tab(3'd4, {1'b0, y_sym})),
    .best(cell_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      oval_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt; c_r <= c_nxt; diag_r <= diag_nxt; left_r <= left_nxt;
    oedge_r <= oedge_nxt; opos_r <= opos_nxt; oscore_r <= oscore_nxt; oend_r <= oend_nxt;
  end

  // Sequencer: load, per-row fetch, per-cell update, right-edge record, edge emission
  always_comb begin
    st_nxt = st_r; r_nxt = r_r; c_nxt = c_r; diag_nxt = diag_r; left_nxt = left_r;
    oval_nxt = oval_r && !out_ch.ready;
    oedge_nxt = oedge_r; opos_nxt = opos_r; oscore_nxt = oscore_r; oend_nxt = oend_r;
    rd_addr = c_r; lh_addr = r_r; re_addr = r_r;
    row_we = 1'b0; row_wa = AW'(in_ch.position); row_wd = in_ch.value;
    re_we = 1'b0; re_wa = '0; re_wd = rd_q;
    case (st_r)
      ST_LOAD: begin
        rd_addr = w_c;
        if (in_fire) begin
          row_we = (in_ch.req_type == REQ_TOP) && 32'(in_ch.position) <= MAX_TILE;
          if (in_ch.last) begin
            st_nxt = ST_ROWEND;
            r_nxt = '0;
          end
        end
      end
      ST_ROWEND: begin
        // record right edge of row r (rd_q holds row_buffer[w], read last cycle)
        rd_addr = '0;
        lh_addr = r_r + AW'(1);
        re_we = 1'b1; re_wa = r_r; re_wd = rd_q;
        if (r_r == h_c) begin
          st_nxt = ST_EMIT_B; c_nxt = '0; rd_addr = '0;
        end else begin
          r_nxt = r_r + AW'(1);
          st_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // rd_q = row_buffer[0] (diag), lh_q = left halo of this row
        diag_nxt = rd_q; left_nxt = lh_q;
        row_we = 1'b1; row_wa = '0; row_wd = lh_q;
        rd_addr = AW'(1); c_nxt = AW'(1);
        if (w_c == '0) begin
          st_nxt = ST_ROWEND; rd_addr = '0;
        end else st_nxt = ST_CELL;
      end
      ST_CELL: begin
        row_we = 1'b1; row_wa = c_r; row_wd = cell_v;
        diag_nxt = rd_q; left_nxt = cell_v;
        if (c_r == w_c) begin
          st_nxt = ST_ROWEND; rd_addr = w_c;
        end else begin
          c_nxt = c_r + AW'(1); rd_addr = c_r + AW'(1);
        end
      end
      ST_EMIT_B: begin
        // rd_q holds row_buffer[c_r]
        if (out_free) begin
          oval_nxt = 1'b1; oedge_nxt = 1'b0; opos_nxt = DimW'(c_r);
          oscore_nxt = rd_q; oend_nxt = 1'b0;
          if (c_r == w_c) begin
            st_nxt = ST_EMIT_R; r_nxt = '0; re_addr = '0;
          end else begin
            c_nxt = c_r + AW'(1); rd_addr = c_r + AW'(1);
          end
        end
      end
      ST_EMIT_R: begin
        if (out_free) begin
          oval_nxt = 1'b1; oedge_nxt = 1'b1; opos_nxt = DimW'(r_r);
          oscore_nxt = re_q; oend_nxt = (r_r == h_c);
          if (r_r == h_c) st_nxt = ST_LOAD;
          else begin
            r_nxt = r_r + AW'(1); re_addr = r_r + AW'(1);
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  assign out_ch.valid = oval_r;
  assign out_ch.edge_res = oedge_r;
  assign out_ch.position_res = opos_r;
  assign out_ch.score = oscore_r;
  assign out_ch.end_of_run = oend_r;

  // Checks
  a_noload: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_LOAD) |-> !in_ch.ready) else $error("load taken while scoring");
  a_endstate: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_nxt && oend_nxt && out_free && st_r == ST_EMIT_R) |=> st_r == ST_LOAD)
    else $error("run did not finish after end value");
  a_colrange: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CELL) |-> (c_r >= AW'(1) && c_r <= w_c)) else $error("column out of range");
endmodule

// ----- dv/alignment_tile_score_tb.sv -----
// Testbench for alignment_tile_score: random load/score transfers checked against a predictor.
// Depends on ats_pkg, the ats_in_if/ats_out_if interfaces and the RTL top level.
class tile_scoreboard;
  localparam int MaxTile = 15;

  typedef struct {
    logic              edge_res;
    logic [3:0]        position_res;
    logic signed [31:0] score;
    logic              end_of_run;
  } edge_value_t;

  logic [3:0]         width_reg;
  logic [3:0]         height_reg;
  logic [39:0]        pair_rows[5];
  logic signed [31:0] top_row[MaxTile+1];
  logic signed [31:0] left_col[MaxTile+1];
  logic signed [31:0] right_col[MaxTile+1];
  logic [1:0]         col_sym[MaxTile];
  logic [1:0]         row_sym[MaxTile];
  edge_value_t        expected_edges[$];
  int                 errors;

  function new();
    width_reg  = 4'd15;
    height_reg = 4'd15;
    foreach (pair_rows[i]) pair_rows[i] = '0;
    errors = 0;
  endfunction

  function void write_reg(ats_pkg::cfg_idx_t idx, logic [39:0] data);
    case (idx)
      ats_pkg::CFG_WIDTH:  width_reg  = data[3:0];
      ats_pkg::CFG_HEIGHT: height_reg = data[3:0];
      default:             pair_rows[int'(idx) - int'(ats_pkg::CFG_ROW_A)] = data;
    endcase
  endfunction

  function longint pair_score(int r, int c);
    logic signed [7:0] b;
    b = pair_rows[r][8*c +: 8];
    return longint'(b);
  endfunction

  function logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Store one accepted load; on last, score the tile and queue its edges
  function void note_load(ats_pkg::req_t req, logic [3:0] pos, logic signed [31:0] v, bit last);
    int w, h, x, y;
    logic signed [31:0] diag, above, d, l, t, m;
    edge_value_t ev;
    case (req)
      ats_pkg::REQ_TOP:  top_row[pos] = v;
      ats_pkg::REQ_LEFT: left_col[pos] = v;
      ats_pkg::REQ_COL:  if (pos < MaxTile) col_sym[pos] = v[1:0];
      default:           if (pos < MaxTile) row_sym[pos] = v[1:0];
    endcase
    if (!last) return;
    w = (width_reg > MaxTile) ? MaxTile : width_reg;
    h = (height_reg > MaxTile) ? MaxTile : height_reg;
    right_col[0] = top_row[w];
    for (int r = 1; r <= h; r++) begin
      y = row_sym[r-1];
      diag = top_row[0];
      top_row[0] = left_col[r];
      for (int c = 1; c <= w; c++) begin
        x = col_sym[c-1];
        above = top_row[c];
        d = clip(longint'(diag) + pair_score(y, x));
        l = clip(longint'(top_row[c-1]) + pair_score(x, 4));
        t = clip(longint'(above) + pair_score(4, y));
        m = l;
        if (t > m) m = t;
        if (d > m) m = d;
        top_row[c] = m;
        diag = above;
      end
      right_col[r] = top_row[w];
    end
    for (int c = 0; c <= w; c++) begin
      ev = '{1'b0, 4'(c), top_row[c], 1'b0};
      expected_edges.push_back(ev);
    end
    for (int r = 0; r <= h; r++) begin
      ev = '{1'b1, 4'(r), right_col[r], (r == h)};
      expected_edges.push_back(ev);
    end
  endfunction

  // Compare one result transfer with the oldest expectation
  function void check_edge(logic e, logic [3:0] p, logic signed [31:0] s, logic eor);
    edge_value_t ev;
    if (expected_edges.size() == 0) begin
      $error("unexpected result: edge_res=%0d position_res=%0d score=%0d", e, p, s);
      errors++;
      return;
    end
    ev = expected_edges.pop_front();
    if (e !== ev.edge_res) begin
      $error("edge_res: expected %0d actual %0d", ev.edge_res, e);
      errors++;
    end
    if (p !== ev.position_res) begin
      $error("position_res: expected %0d actual %0d", ev.position_res, p);
      errors++;
    end
    if (s !== ev.score) begin
      $error("score: expected %0d actual %0d", ev.score, s);
      errors++;
    end
    if (eor !== ev.end_of_run) begin
      $error("end_of_run: expected %0d actual %0d", ev.end_of_run, eor);
      errors++;
    end
  endfunction

  function int pending();
    return expected_edges.size();
  endfunction
endclass

module alignment_tile_score_tb import ats_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  ats_in_if  in_ch();
  ats_out_if out_ch();

  alignment_tile_score dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  tile_scoreboard sb = new();
  int  loads_sent = 0;
  int  burst_left = 0;
  bit  gaps_on    = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive every input known from time zero
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.position = '0;
    in_ch.value = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Receiver: alternate between free-flowing, light and heavy stall stretches
  initial begin
    int mode;
    int span;
    span = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(5, 40);
      end
      span--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 3) != 0);
        default: out_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_edge(out_ch.edge_res, out_ch.position_res, out_ch.score, out_ch.end_of_run);
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  // Send one load; hold until transfer, with bursts and gaps around it
  task automatic send_load(req_t req, logic [3:0] pos, logic [31:0] v, bit last);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.req_type = req;
    in_ch.position = pos;
    in_ch.value = v;
    in_ch.last = last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_load(req, pos, v, last);
    loads_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid = 1'b0;
    in_ch.last = 1'b0;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [39:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_value(req_t req);
    if (req == REQ_COL || req == REQ_ROW) return $urandom;
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [39:0] pick_row();
    case ($urandom_range(0, 5))
      0: return 40'h7F7F7F7F7F;
      1: return 40'h8080808080;
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd1;
      default: return 4'($urandom_range(1, 6));
    endcase
  endfunction

  // Random loads followed by a random load marked last
  task automatic run_tile(int n);
    req_t req;
    for (int i = 0; i <= n; i++) begin
      req = req_t'($urandom_range(0, 3));
      send_load(req, 4'($urandom_range(0, 15)), pick_value(req), i == n);
    end
  endtask

  // Wait for every expected edge, then let the block settle
  task automatic wait_idle();
    release_input();
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    int tiles;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill every store so no entry is read unwritten
    for (int p = 0; p <= 15; p++) begin
      send_load(REQ_TOP, 4'(p), pick_value(REQ_TOP), 1'b0);
      send_load(REQ_LEFT, 4'(p), pick_value(REQ_LEFT), 1'b0);
    end
    for (int p = 0; p < 15; p++) begin
      send_load(REQ_COL, 4'(p), $urandom, 1'b0);
      send_load(REQ_ROW, 4'(p), $urandom, 1'b0);
    end

    // Directed: reset settings, full tile, zero table
    run_tile(0);
    wait_idle();
    // Zero dimensions emit the halo values themselves
    write_reg(CFG_WIDTH, 40'd0);
    write_reg(CFG_HEIGHT, 40'd0);
    send_load(REQ_TOP, 4'd0, 32'h7FFF_FFFF, 1'b1);
    wait_idle();
    write_reg(CFG_WIDTH, 40'd15);
    send_load(REQ_LEFT, 4'd0, 32'h1234_5678, 1'b1);
    wait_idle();
    write_reg(CFG_WIDTH, 40'd0);
    write_reg(CFG_HEIGHT, 40'd15);
    send_load(REQ_COL, 4'd15, 32'hFFFF_FFFF, 1'b1);
    wait_idle();
    // Saturate high, then low, on a small tile
    write_reg(CFG_WIDTH, 40'd2);
    write_reg(CFG_HEIGHT, 40'd2);
    for (int i = 0; i < 5; i++) write_reg(cfg_idx_t'(int'(CFG_ROW_A) + i), 40'h7F7F7F7F7F);
    send_load(REQ_TOP, 4'd0, 32'h7FFF_FFFF, 1'b0);
    send_load(REQ_TOP, 4'd1, 32'h7FFF_FFFF, 1'b0);
    send_load(REQ_LEFT, 4'd1, 32'h7FFF_FFF0, 1'b0);
    send_load(REQ_ROW, 4'd15, 32'h0000_0002, 1'b0);
    send_load(REQ_COL, 4'd0, 32'hFFFF_FFFE, 1'b1);
    wait_idle();
    for (int i = 0; i < 5; i++) write_reg(cfg_idx_t'(int'(CFG_ROW_A) + i), 40'h8080808080);
    send_load(REQ_TOP, 4'd0, 32'h8000_0000, 1'b0);
    send_load(REQ_LEFT, 4'd1, 32'h8000_0001, 1'b0);
    send_load(REQ_LEFT, 4'd2, 32'h8000_0000, 1'b1);
    wait_idle();
    // Halo reuse: score again with nothing reloaded but one symbol
    send_load(REQ_ROW, 4'd0, 32'h0000_0003, 1'b1);
    wait_idle();

    // Random phases with fresh settings each time
    while (loads_sent < 430) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      write_reg(CFG_WIDTH, 40'(pick_dim()));
      write_reg(CFG_HEIGHT, 40'(pick_dim()));
      for (int i = 0; i < 5; i++) write_reg(cfg_idx_t'(int'(CFG_ROW_A) + i), pick_row());
      tiles = $urandom_range(1, 4);
      repeat (tiles) run_tile($urandom_range(3, 10));
      wait_idle();
    end

    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
